>>> rtl/sha256_pkg.sv
// constants and types shared by the sha-256 digest block
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam logic [60:0] MsgMax     = {61{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> rtl/sha256_round.sv
// one sha-256 round step and schedule word update
module sha256_round
  import sha256_pkg::*;
(
  input  logic [31:0] vars_in [8],
  input  logic [31:0] k,
  input  logic [31:0] w,
  input  logic [31:0] x2,
  input  logic [31:0] x7,
  input  logic [31:0] x15,
  input  logic [31:0] x16,
  output logic [31:0] w_sched,
  output logic [31:0] vars_out [8]
);

  logic [31:0] s0, s1, t1, t2, e, a;

  always_comb begin
    s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    w_sched = x16 + s0 + x7 + s1;
    a = vars_in[0];
    e = vars_in[4];
    t1 = vars_in[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & vars_in[5]) ^ (~e & vars_in[6])) + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & vars_in[1]) ^ (a & vars_in[2]) ^ (vars_in[1] & vars_in[2]));
    vars_out[7] = vars_in[6];
    vars_out[6] = vars_in[5];
    vars_out[5] = vars_in[4];
    vars_out[4] = vars_in[3] + t1;
    vars_out[3] = vars_in[2];
    vars_out[2] = vars_in[1];
    vars_out[1] = a;
    vars_out[0] = t1 + t2;
  end

endmodule

>>> rtl/sha256_message_digest.sv
// sha-256 digest of a byte stream, top level
// Bytes are taken one per word and collected into a 64-byte block memory
// (one write and one read per cycle, read data registered). After a byte
// that does not complete a block the next word can be taken. The 64th byte
// of a block starts a compression: ST_LOAD moves the block into the schedule
// registers, ST_ROUND runs the rounds, ST_ADD adds into the chaining words;
// no word is taken while a compression runs. A word with last pads the tail
// in the block memory, one byte a cycle, runs one or two compressions and
// then offers the digest; the next word is taken once the digest word has
// left.
module sha256_message_digest
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // byte_present
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // digest_w0, digest_w1, digest_w2, digest_w3
  output logic         m_tuser    // length_error
);

  logic [7:0]  blk_mem [64];
  logic [7:0]  blk_rd;
  logic        mem_we;
  logic [5:0]  mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  state_t      state, state_next;
  logic [60:0] msg_bytes;
  logic        ovf;
  logic [31:0] chain [8];
  logic [31:0] vars [8];
  logic [31:0] sched [16];
  logic [6:0]  cnt;
  logic        final_mode;
  logic        len_done;
  logic        pad_two;
  logic [31:0] vars_out [8];
  logic [31:0] w_sched, w_cur;
  logic        accept;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_wa] <= mem_wd;
    end
    blk_rd <= blk_mem[mem_ra];
  end

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  assign w_cur = (cnt[5:0] < 6'd16) ? sched[cnt[3:0]] : w_sched;

  sha256_round u_round (
    .vars_in  (vars),
    .k        (RoundK[cnt[5:0]]),
    .w        (w_cur),
    .x2       (sched[4'(cnt[3:0] - 4'd2)]),
    .x7       (sched[4'(cnt[3:0] - 4'd7)]),
    .x15      (sched[4'(cnt[3:0] - 4'd15)]),
    .x16      (sched[cnt[3:0]]),
    .w_sched  (w_sched),
    .vars_out (vars_out)
  );

  logic take_byte;
  assign take_byte = accept && s_tuser && (msg_bytes != MsgMax);

  // pad byte for the current position
  logic [5:0]  pad_pos;
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  logic [2:0]  len_idx;
  assign pad_pos = cnt[5:0];
  assign bits = {msg_bytes, 3'b000};
  assign len_idx = 3'(6'd63 - pad_pos);
  always_comb begin
    if (pad_pos == msg_bytes[5:0] && !pad_two) begin
      pad_byte = 8'h80;
    end else if (len_done && pad_pos >= 6'd56) begin
      pad_byte = bits[len_idx*8 +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = msg_bytes[5:0];
    mem_wd = s_tdata;
    mem_ra = cnt[5:0];
    unique case (state)
      ST_IDLE: begin
        mem_we = take_byte;
      end
      ST_PAD: begin
        mem_we = 1'b1;
        mem_wa = pad_pos;
        mem_wd = pad_byte;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // pad run: start position and whether length fits
  logic        last_pend;
  logic [5:0]  tail_pos;
  assign tail_pos = take_byte ? msg_bytes[5:0] + 6'd1 : msg_bytes[5:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (take_byte && msg_bytes[5:0] == 6'd63) begin
            state_next = ST_LOAD;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD:  if (cnt == 7'd64) state_next = ST_ROUND;
      ST_ROUND: if (cnt == 7'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (!final_mode) begin
          state_next = last_pend ? ST_PAD : ST_IDLE;
        end else if (len_done) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD:   if (cnt == 7'd63) state_next = ST_LOAD;
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      msg_bytes  <= '0;
      ovf        <= 1'b0;
      cnt        <= '0;
      final_mode <= 1'b0;
      len_done   <= 1'b0;
      pad_two    <= 1'b0;
      last_pend  <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= InitH[i];
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (s_tuser && msg_bytes == MsgMax) ovf <= 1'b1;
            if (take_byte) msg_bytes <= msg_bytes + 61'd1;
            last_pend <= s_tlast;
            if (s_tlast && !(take_byte && msg_bytes[5:0] == 6'd63)) begin
              final_mode <= 1'b1;
              len_done <= (tail_pos < 6'd56);
              pad_two <= 1'b0;
              cnt <= {1'b0, tail_pos};
            end
          end
        end
        ST_LOAD: begin
          cnt <= cnt + 7'd1;
          if (cnt != 7'd0) begin
            sched[4'(6'(cnt - 7'd1) >> 2)] <=
              {sched[4'(6'(cnt - 7'd1) >> 2)][23:0], blk_rd};
          end
          if (cnt == 7'd64) begin
            cnt <= '0;
            for (int i = 0; i < 8; i++) vars[i] <= chain[i];
          end
        end
        ST_ROUND: begin
          cnt <= cnt + 7'd1;
          vars <= vars_out;
          if (cnt[5:0] >= 6'd16) sched[cnt[3:0]] <= w_sched;
        end
        ST_ADD: begin
          cnt <= '0;
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
          if (!final_mode && last_pend) begin
            final_mode <= 1'b1;
            len_done <= 1'b1;
            pad_two <= 1'b0;
          end else if (final_mode && !len_done) begin
            len_done <= 1'b1;
            pad_two <= 1'b1;
          end
        end
        ST_PAD: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) cnt <= '0;
        end
        ST_OUT: begin
          if (m_tready) begin
            for (int i = 0; i < 8; i++) chain[i] <= InitH[i];
            msg_bytes  <= '0;
            ovf        <= 1'b0;
            final_mode <= 1'b0;
            last_pend  <= 1'b0;
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

  // load reads 4 bytes per word big-endian; block byte 4i..4i+3 into word i
  // is done with 64 reads, with cnt stepping over the 64 block addresses
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {chain[6], chain[7], chain[4], chain[5],
                     chain[2], chain[3], chain[0], chain[1]};
  assign m_tuser  = ovf;

endmodule

>>> test/sha256_message_digest_test.sv
// self-checking testbench for the sha-256 byte stream digest block
module sha256_message_digest_test;
  import sha256_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
    bit         drain_first;
  } byte_word_t;

  typedef struct {
    logic [63:0] w [4];
    logic        length_error;
  } digest_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [255:0] m_tdata;
  logic         m_tuser;

  sha256_message_digest dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_word_t  pending_words [$];
  digest_t     digests_due [$];
  logic [31:0] hash_words [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] byte_count;
  logic        count_saturated;
  int          mismatches = 0;
  int          digests_seen = 0;
  int          messages_sent = 0;
  int          bytes_sent = 0;
  bit          taken = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_phase = 0;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] w, t1, t2, x2, x15;
    for (int i = 0; i < 16; i++)
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        w = sched[i];
      end else begin
        x2 = sched[(i - 2) & 15];
        x15 = sched[(i - 15) & 15];
        w = sched[i & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) +
            sched[(i - 7) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
        sched[i & 15] = w;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_words[i] = InitH[i];
    byte_count = '0;
    count_saturated = 1'b0;
  endtask

  task automatic absorb_word(input byte_word_t bw);
    int pos;
    logic [63:0] bits;
    digest_t d;
    if (bw.byte_present) begin
      if (byte_count == MsgMax) begin
        count_saturated = 1'b1;
      end else begin
        pos = int'(byte_count[5:0]);
        block_bytes[pos] = bw.data_byte;
        byte_count++;
        if (pos == 63) compress_block();
      end
    end
    if (!bw.last) return;
    pos = int'(byte_count[5:0]);
    block_bytes[pos] = 8'h80;
    for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (pos >= 56) begin
      compress_block();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    bits = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[63 - i] = bits[8*i +: 8];
    compress_block();
    for (int i = 0; i < 4; i++) d.w[i] = {hash_words[2*i], hash_words[2*i+1]};
    d.length_error = count_saturated;
    digests_due.push_back(d);
    restart_message();
  endtask

  function automatic void queue_word(input logic [7:0] b, input logic p, input logic l,
                                     input bit drain);
    byte_word_t bw;
    bw.data_byte = b;
    bw.byte_present = p;
    bw.last = l;
    bw.drain_first = drain;
    pending_words.push_back(bw);
    if (p) bytes_sent++;
    if (l) messages_sent++;
  endfunction

  function automatic void queue_message(input int len, input bit drain);
    bit tail_absent;
    tail_absent = ($urandom_range(0, 5) == 0);
    if (len == 0) tail_absent = 1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_word(8'($urandom), 1'b0, 1'b0, 0);
      queue_word(8'($urandom), 1'b1, (i == len - 1) && !tail_absent, drain && i == 0);
    end
    if (tail_absent) queue_word(8'($urandom), 1'b0, 1'b1, drain && len == 0);
  endfunction

  // sender, bursts with gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken) begin
      taken <= 0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].drain_first && digests_due.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words[0].data_byte;
        s_tuser <= pending_words[0].byte_present;
        s_tlast <= pending_words[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = 16'hFFFF;
        1: stall_pattern = 16'h0001;
        default: stall_pattern = 16'($urandom);
      endcase
    end
    m_tready <= rst ? 1'b0 : stall_pattern[stall_phase];
    stall_phase = (stall_phase + 1) % 16;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      absorb_word(pending_words.pop_front());
      taken <= 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      digests_seen++;
      if (digests_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest %h", m_tdata);
      end else begin
        digest_t d;
        d = digests_due.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_tdata[64*i +: 64] !== d.w[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest_w%0d: expected %h, got %h", i, d.w[i], m_tdata[64*i +: 64]);
          end
        if (m_tuser !== d.length_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("length_error: expected %b, got %b", d.length_error, m_tuser);
        end
      end
    end
  end

  initial begin
    int len;
    restart_message();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    // empty message, single extreme bytes, "abc" with a hole, tail without byte
    queue_word(8'hFF, 1'b0, 1'b1, 0);
    queue_word(8'h00, 1'b1, 1'b1, 0);
    queue_word(8'hFF, 1'b1, 1'b1, 0);
    queue_word(8'h61, 1'b1, 1'b0, 1);
    queue_word(8'hAA, 1'b0, 1'b0, 0);
    queue_word(8'h62, 1'b1, 1'b0, 0);
    queue_word(8'h63, 1'b1, 1'b1, 0);
    queue_word(8'h55, 1'b1, 1'b0, 0);
    queue_word(8'h00, 1'b0, 1'b0, 0);
    queue_word(8'hFF, 1'b0, 1'b1, 0);
    while (pending_words.size() < 1800 || messages_sent < 40) begin
      case ($urandom_range(0, 2))
        0: len = $urandom_range(0, 20);
        1: len = $urandom_range(52, 72);
        default: len = $urandom_range(0, 140);
      endcase
      queue_message(len, $urandom_range(0, 4) == 0);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && digests_due.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d messages, %0d bytes sent; %0d digests compared, padding in one and two blocks",
             messages_sent, bytes_sent, digests_seen);
    if (mismatches == 0 && digests_due.size() == 0)
      $display("sha256_message_digest: match");
    else
      $display("sha256_message_digest: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("sha256_message_digest: mismatch");
    $finish;
  end

endmodule
